// File: src/qve_pkg.sv
// Shared types, constants and helpers for the rotated quad vertex expander.
// Used by every module of the block; depends on nothing.
package qve_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 14;
  localparam int unsigned CFG_DATA_W = 14;

  typedef enum logic [0:0] {
    CFG_SCREEN_W = 1'b0,
    CFG_SCREEN_H = 1'b1
  } cfg_reg_e;

  localparam logic [CFG_DATA_W-1:0] SCREEN_W_RST = 14'd1920;
  localparam logic [CFG_DATA_W-1:0] SCREEN_H_RST = 14'd1080;

  localparam logic [2:0] LAST_IDX = 3'd5;

  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [17:0] ONE_Q14 = 18'sd16384;

  localparam logic [31:0] ATAN_TAB [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BR = 2'd2,
    CORNER_BL = 2'd3
  } corner_e;

  typedef enum logic [1:0] {
    SAT_NONE = 2'd0,
    SAT_LOW  = 2'd1,
    SAT_HIGH = 2'd2
  } sat_e;

  typedef struct packed {
    logic [15:0] tu;
    logic [15:0] tv;
    logic [31:0] color;
    logic [2:0]  idx;
    logic        last;
  } attr_t;

  typedef struct packed {
    logic signed [17:0] mid_x;
    logic signed [17:0] mid_y;
    logic signed [16:0] ox;
    logic signed [16:0] oy;
    attr_t              attr;
  } vtx_t;

  function automatic corner_e corner_of(input logic [2:0] idx);
    corner_e c;
    case (idx)
      3'd0: c = CORNER_TL;
      3'd1: c = CORNER_TR;
      3'd2: c = CORNER_BR;
      3'd3: c = CORNER_TL;
      3'd4: c = CORNER_BR;
      3'd5: c = CORNER_BL;
      default: c = CORNER_TL;
    endcase
    return c;
  endfunction

endpackage

// File: src/qve_if.sv
// Valid/ready channel interfaces for quads in and vertices out.
// Depends on nothing; used by the top level and the quad sequencer.
interface qve_quad_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [15:0]        rect_width;
  logic [15:0]        rect_height;
  logic [15:0]        angle;
  logic signed [15:0] u_min;
  logic signed [15:0] v_min;
  logic signed [15:0] u_max;
  logic signed [15:0] v_max;
  logic [31:0]        color_rgba;
  modport source(output valid, pos_x, pos_y, rect_width, rect_height, angle,
                 u_min, v_min, u_max, v_max, color_rgba, input ready);
  modport sink(input valid, pos_x, pos_y, rect_width, rect_height, angle,
               u_min, v_min, u_max, v_max, color_rgba, output ready);
endinterface

interface qve_vtx_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] ndc_x;
  logic signed [15:0] ndc_y;
  logic signed [15:0] tex_u;
  logic signed [15:0] tex_v;
  logic [31:0]        vertex_color;
  logic [2:0]         vertex_index;
  logic               last;
  modport source(output valid, ndc_x, ndc_y, tex_u, tex_v, vertex_color,
                 vertex_index, last, input ready);
  modport sink(input valid, ndc_x, ndc_y, tex_u, tex_v, vertex_color,
               vertex_index, last, output ready);
endinterface

// File: src/qve_seq.sv
// Quad sequencer: holds one quad and issues its six vertices, one per cycle
// while adv_i is high. Depends on qve_pkg and qve_quad_if.
module qve_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  qve_quad_if.sink       in_if,
  output logic           vld_o,
  output logic [15:0]    ang_o,
  output qve_pkg::vtx_t  vtx_o
);

  logic                busy_q;
  logic [2:0]          cnt_q;
  logic signed [15:0]  px_q, py_q, u0_q, v0_q, u1_q, v1_q;
  logic [15:0]         w_q, h_q, ang_q;
  logic [31:0]         col_q;
  logic                acc;
  qve_pkg::corner_e    corner;
  logic                right, bottom;
  logic signed [16:0]  hw, hh;

  assign in_if.ready = adv_i && (!busy_q || cnt_q == qve_pkg::LAST_IDX);
  assign acc = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (adv_i) begin
      if (acc) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == qve_pkg::LAST_IDX) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      px_q  <= in_if.pos_x;
      py_q  <= in_if.pos_y;
      w_q   <= in_if.rect_width;
      h_q   <= in_if.rect_height;
      ang_q <= in_if.angle;
      u0_q  <= in_if.u_min;
      v0_q  <= in_if.v_min;
      u1_q  <= in_if.u_max;
      v1_q  <= in_if.v_max;
      col_q <= in_if.color_rgba;
    end
  end

  always_comb begin
    corner = qve_pkg::corner_of(cnt_q);
    right  = (corner == qve_pkg::CORNER_TR) || (corner == qve_pkg::CORNER_BR);
    bottom = (corner == qve_pkg::CORNER_BR) || (corner == qve_pkg::CORNER_BL);
    hw = $signed({1'b0, w_q});
    hh = $signed({1'b0, h_q});
    vtx_o.mid_x = $signed({px_q[15], px_q, 1'b0}) + $signed({2'b00, w_q});
    vtx_o.mid_y = $signed({py_q[15], py_q, 1'b0}) + $signed({2'b00, h_q});
    vtx_o.ox = right ? hw : -hw;
    vtx_o.oy = bottom ? hh : -hh;
    vtx_o.attr.tu    = right ? u1_q : u0_q;
    vtx_o.attr.tv    = bottom ? v1_q : v0_q;
    vtx_o.attr.color = col_q;
    vtx_o.attr.idx   = cnt_q;
    vtx_o.attr.last  = (cnt_q == qve_pkg::LAST_IDX);
  end

  assign vld_o = busy_q;
  assign ang_o = ang_q;

endmodule

// File: src/qve_cordic.sv
// Pipelined CORDIC in rotation mode giving cosine and sine in Q4.14.
// One stage per iteration; the vertex word travels alongside. Uses qve_pkg.
module qve_cordic #(
  parameter int unsigned STAGES = qve_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               vld_i,
  input  logic [15:0]        ang_i,
  input  qve_pkg::vtx_t      side_i,
  output logic               vld_o,
  output logic signed [17:0] co_o,
  output logic signed [17:0] si_o,
  output qve_pkg::vtx_t      side_o
);

  logic                v_q    [STAGES+1];
  logic signed [33:0]  x_q    [STAGES+1];
  logic signed [33:0]  y_q    [STAGES+1];
  logic signed [33:0]  z_q    [STAGES+1];
  logic                flip_q [STAGES+1];
  logic                zero_q [STAGES+1];
  qve_pkg::vtx_t       s_q    [STAGES+1];

  logic                flip_in;
  logic [31:0]         za;
  logic signed [33:0]  xf, yf, xr, yr;
  logic                vo_q;
  logic signed [17:0]  co_q, si_q;
  qve_pkg::vtx_t       so_q;

  assign flip_in = (ang_i >= 16'd16384) && (ang_i < 16'd49152);
  assign za = {ang_i, 16'h0000} + (flip_in ? 32'h8000_0000 : 32'h0000_0000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (adv_i) begin
      v_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q[0]    <= qve_pkg::GAIN_Q30;
      y_q[0]    <= '0;
      z_q[0]    <= 34'($signed(za));
      flip_q[0] <= flip_in;
      zero_q[0] <= (ang_i == 16'd0);
      s_q[0]    <= side_i;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [33:0] atan;
    assign atan = $signed({2'b00, qve_pkg::ATAN_TAB[i]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (adv_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        if (!z_q[i][33]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan;
        end
        flip_q[i+1] <= flip_q[i];
        zero_q[i+1] <= zero_q[i];
        s_q[i+1]    <= s_q[i];
      end
    end
  end

  always_comb begin
    xf = flip_q[STAGES] ? -x_q[STAGES] : x_q[STAGES];
    yf = flip_q[STAGES] ? -y_q[STAGES] : y_q[STAGES];
    xr = xf + 34'sd32768;
    yr = yf + 34'sd32768;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (adv_i) begin
      vo_q <= v_q[STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      co_q <= zero_q[STAGES] ? qve_pkg::ONE_Q14 : xr[33:16];
      si_q <= zero_q[STAGES] ? 18'sd0 : yr[33:16];
      so_q <= s_q[STAGES];
    end
  end

  assign vld_o  = vo_q;
  assign co_o   = co_q;
  assign si_o   = si_q;
  assign side_o = so_q;

endmodule

// File: src/qve_div.sv
// Pipelined restoring divider, one quotient bit per stage, for x and y at once.
// Turns offset numerators into saturated Q4.12 device coordinates. Uses qve_pkg.
module qve_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               vld_i,
  input  logic [29:0]        tx_i,
  input  logic [29:0]        ty_i,
  input  qve_pkg::sat_e      sx_i,
  input  qve_pkg::sat_e      sy_i,
  input  logic [13:0]        dx_i,
  input  logic [13:0]        dy_i,
  input  qve_pkg::attr_t     attr_i,
  output logic               vld_o,
  output logic signed [15:0] ndc_x_o,
  output logic signed [15:0] ndc_y_o,
  output qve_pkg::attr_t     attr_o
);

  localparam int unsigned QW = 16;

  logic               v_q  [QW+1];
  logic [29:0]        rx_q [QW+1];
  logic [29:0]        ry_q [QW+1];
  logic [QW-1:0]      qx_q [QW+1];
  logic [QW-1:0]      qy_q [QW+1];
  qve_pkg::sat_e      sx_q [QW+1];
  qve_pkg::sat_e      sy_q [QW+1];
  qve_pkg::attr_t     a_q  [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (adv_i) begin
      v_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rx_q[0] <= tx_i;
      ry_q[0] <= ty_i;
      qx_q[0] <= '0;
      qy_q[0] <= '0;
      sx_q[0] <= sx_i;
      sy_q[0] <= sy_i;
      a_q[0]  <= attr_i;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [29:0] cx, cy;
    logic        gx, gy;
    assign cx = 30'(dx_i) << (QW - 1 - s);
    assign cy = 30'(dy_i) << (QW - 1 - s);
    assign gx = rx_q[s] >= cx;
    assign gy = ry_q[s] >= cy;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (adv_i) begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rx_q[s+1] <= gx ? rx_q[s] - cx : rx_q[s];
        ry_q[s+1] <= gy ? ry_q[s] - cy : ry_q[s];
        qx_q[s+1] <= {qx_q[s][QW-2:0], gx};
        qy_q[s+1] <= {qy_q[s][QW-2:0], gy};
        sx_q[s+1] <= sx_q[s];
        sy_q[s+1] <= sy_q[s];
        a_q[s+1]  <= a_q[s];
      end
    end
  end

  always_comb begin
    case (sx_q[QW])
      qve_pkg::SAT_LOW:  ndc_x_o = 16'sh8000;
      qve_pkg::SAT_HIGH: ndc_x_o = 16'sh7FFF;
      default:           ndc_x_o = $signed({~qx_q[QW][15], qx_q[QW][14:0]});
    endcase
    case (sy_q[QW])
      qve_pkg::SAT_LOW:  ndc_y_o = 16'sh8000;
      qve_pkg::SAT_HIGH: ndc_y_o = 16'sh7FFF;
      default:           ndc_y_o = $signed({~qy_q[QW][15], qy_q[QW][14:0]});
    endcase
  end

  assign vld_o  = v_q[QW];
  assign attr_o = a_q[QW];

endmodule

// File: src/rotated_quad_vertex_expander.sv
// Top level: rotates the corners of an overlay rectangle and emits six vertices.
// Depends on qve_pkg, qve_if, qve_seq, qve_cordic and qve_div.
//
//   channel  | dir | handshake      | word
//   in_if    | in  | valid / ready  | one quad: position, size, angle, UV, color
//   out_if   | out | valid / ready  | one vertex: NDC, UV, color, index, last
//   cfg      | in  | cfg_we_i       | screen width (index 0), height (index 1)
//
// A quad is taken when the sequencer is idle or on its sixth vertex; the six
// output vertices of one quad leave one per cycle unless out_if stalls.
// Each vertex passes CORDIC, multiply, sum, bias, divider and output registers.
// All stages advance together whenever the output register is empty or taken,
// so a stall freezes the pipeline without loss. Reset clears the valid bits
// and loads the screen size registers with 1920 by 1080.
module rotated_quad_vertex_expander #(
  parameter int unsigned CORDIC_STAGES = qve_pkg::CORDIC_STAGES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_idx_i,
  input  logic [qve_pkg::CFG_DATA_W-1:0] cfg_data_i,
  qve_quad_if.sink                       in_if,
  qve_vtx_if.source                      out_if
);

  logic [13:0]         scr_w_q, scr_h_q;
  logic [13:0]         div_w, div_h;
  logic [28:0]         k_w, k_h;
  logic                adv;

  logic                seq_vld;
  logic [15:0]         seq_ang;
  qve_pkg::vtx_t       seq_vtx;

  logic                cor_vld;
  logic signed [17:0]  cor_co, cor_si;
  qve_pkg::vtx_t       cor_vtx;

  logic                m_vld_q;
  logic signed [34:0]  m_xc_q, m_ys_q, m_xs_q, m_yc_q;
  logic signed [17:0]  m_mx_q, m_my_q;
  qve_pkg::attr_t      m_attr_q;

  logic                p_vld_q;
  logic signed [35:0]  p_x_q, p_y_q;
  qve_pkg::attr_t      p_attr_q;

  logic signed [35:0]  t_x, t_y;
  logic                t_vld_q;
  logic [29:0]         t_x_q, t_y_q;
  qve_pkg::sat_e       t_sx_q, t_sy_q;
  qve_pkg::attr_t      t_attr_q;

  logic                div_vld;
  logic signed [15:0]  div_nx, div_ny;
  qve_pkg::attr_t      div_attr;

  logic                out_vld_q;
  logic signed [15:0]  out_nx_q, out_ny_q;
  qve_pkg::attr_t      out_attr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= qve_pkg::SCREEN_W_RST;
      scr_h_q <= qve_pkg::SCREEN_H_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qve_pkg::CFG_SCREEN_W: scr_w_q <= cfg_data_i;
        qve_pkg::CFG_SCREEN_H: scr_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero screen size divides as one; the bias 28672 * size folds the
  // minus one and the lower saturation bound into a nonnegative numerator.
  assign div_w = (scr_w_q == '0) ? 14'd1 : scr_w_q;
  assign div_h = (scr_h_q == '0) ? 14'd1 : scr_h_q;
  assign k_w = {div_w, 15'b0} - {3'b0, div_w, 12'b0};
  assign k_h = {div_h, 15'b0} - {3'b0, div_h, 12'b0};

  assign adv = !out_vld_q || out_if.ready;

  qve_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .in_if  (in_if),
    .vld_o  (seq_vld),
    .ang_o  (seq_ang),
    .vtx_o  (seq_vtx)
  );

  qve_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (seq_vld),
    .ang_i  (seq_ang),
    .side_i (seq_vtx),
    .vld_o  (cor_vld),
    .co_o   (cor_co),
    .si_o   (cor_si),
    .side_o (cor_vtx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
      p_vld_q <= 1'b0;
      t_vld_q <= 1'b0;
    end else if (adv) begin
      m_vld_q <= cor_vld;
      p_vld_q <= m_vld_q;
      t_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_xc_q   <= 35'(cor_vtx.ox) * 35'(cor_co);
      m_ys_q   <= 35'(cor_vtx.oy) * 35'(cor_si);
      m_xs_q   <= 35'(cor_vtx.ox) * 35'(cor_si);
      m_yc_q   <= 35'(cor_vtx.oy) * 35'(cor_co);
      m_mx_q   <= cor_vtx.mid_x;
      m_my_q   <= cor_vtx.mid_y;
      m_attr_q <= cor_vtx.attr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_x_q    <= 36'($signed({m_mx_q, 14'b0})) + 36'(m_xc_q) - 36'(m_ys_q);
      p_y_q    <= 36'($signed({m_my_q, 14'b0})) + 36'(m_xs_q) + 36'(m_yc_q);
      p_attr_q <= m_attr_q;
    end
  end

  always_comb begin
    t_x = ((p_x_q + $signed({17'b0, div_w, 5'b0})) >>> 6) + $signed({7'b0, k_w});
    t_y = ((p_y_q + $signed({17'b0, div_h, 5'b0})) >>> 6) + $signed({7'b0, k_h});
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_x_q <= t_x[29:0];
      t_y_q <= t_y[29:0];
      if (t_x[35]) begin
        t_sx_q <= qve_pkg::SAT_LOW;
      end else if (t_x[34:0] >= {5'b0, div_w, 16'b0}) begin
        t_sx_q <= qve_pkg::SAT_HIGH;
      end else begin
        t_sx_q <= qve_pkg::SAT_NONE;
      end
      if (t_y[35]) begin
        t_sy_q <= qve_pkg::SAT_LOW;
      end else if (t_y[34:0] >= {5'b0, div_h, 16'b0}) begin
        t_sy_q <= qve_pkg::SAT_HIGH;
      end else begin
        t_sy_q <= qve_pkg::SAT_NONE;
      end
      t_attr_q <= p_attr_q;
    end
  end

  qve_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .vld_i   (t_vld_q),
    .tx_i    (t_x_q),
    .ty_i    (t_y_q),
    .sx_i    (t_sx_q),
    .sy_i    (t_sy_q),
    .dx_i    (div_w),
    .dy_i    (div_h),
    .attr_i  (t_attr_q),
    .vld_o   (div_vld),
    .ndc_x_o (div_nx),
    .ndc_y_o (div_ny),
    .attr_o  (div_attr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_nx_q   <= div_nx;
      out_ny_q   <= div_ny;
      out_attr_q <= div_attr;
    end
  end

  assign out_if.valid        = out_vld_q;
  assign out_if.ndc_x        = out_nx_q;
  assign out_if.ndc_y        = out_ny_q;
  assign out_if.tex_u        = $signed(out_attr_q.tu);
  assign out_if.tex_v        = $signed(out_attr_q.tv);
  assign out_if.vertex_color = out_attr_q.color;
  assign out_if.vertex_index = out_attr_q.idx;
  assign out_if.last         = out_attr_q.last;

  a_last_idx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.last |-> out_if.vertex_index == qve_pkg::LAST_IDX)
    else $error("last flag on a vertex other than the sixth");

  a_idx_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.ready && out_if.vertex_index != qve_pkg::LAST_IDX
    |=> out_if.valid && out_if.vertex_index == $past(out_if.vertex_index) + 3'd1)
    else $error("vertices of a quad not delivered back to back in order");

  a_seq_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready
    |-> !seq_vld || seq_vtx.attr.idx == qve_pkg::LAST_IDX)
    else $error("quad accepted while the sequencer still holds unissued vertices");

endmodule
